/* rtl/core/vfc_pkg.sv */
// Package for the culled voxel face mesher: chunk geometry, field widths,
// command codes, sequencer states, beat structs and the face corner table.
// No dependencies.
package vfc_pkg;

  localparam int CHUNK_EDGE = 16;
  localparam int CELLS      = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
  localparam int ADDR_W     = $clog2(CELLS);

  localparam int COORD_W = 4;
  localparam int VERT_W  = 5;
  localparam int CODE_W  = 6;
  localparam int VOX_W   = 8;
  localparam int CNT_W   = 17;
  localparam int NFACES  = 6;
  localparam int FACE_W  = 3;
  localparam int CORN_W  = 2;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_MESH  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SELF_RD,
    S_SELF_CHK,
    S_NB_RD,
    S_NB_CHK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;
    logic [VOX_W-1:0]   voxel_value;
  } in_beat_t;

  typedef struct packed {
    logic [VERT_W-1:0] vert_x;
    logic [VERT_W-1:0] vert_y;
    logic [VERT_W-1:0] vert_z;
    logic [CODE_W-1:0] corner_code;
    logic [VOX_W-1:0]  vertex_type;
    logic [CNT_W-1:0]  vertex_number;
    logic              last;
  } out_beat_t;

  // corner offsets {dx, dy, dz} per face (+x, -x, +y, -y, +z, -z) and corner
  localparam logic [2:0] FACE_CORNER [NFACES][4] = '{
    '{3'b100, 3'b110, 3'b101, 3'b111},
    '{3'b000, 3'b010, 3'b001, 3'b011},
    '{3'b010, 3'b011, 3'b110, 3'b111},
    '{3'b000, 3'b100, 3'b001, 3'b101},
    '{3'b001, 3'b011, 3'b101, 3'b111},
    '{3'b000, 3'b010, 3'b100, 3'b110}
  };

endpackage

/* rtl/core/voxel_face_culling_mesher.sv */
// Top level of the culled voxel face mesher: command decode, neighbour scan
// sequencer, vertex emitter and vertex counter. Uses vfc_pkg and vfc_ram.
//
// Usage: one command beat enters on in_valid/in_ready with payload in_data.
// A write command stores voxel_value at (cell_x, cell_y, cell_z); a clear
// command zeroes the vertex counter; both finish in the accepting cycle and
// produce no output. A mesh command reads the cell and, if it is non-empty,
// its six neighbours (+x, -x, +y, -y, +z, -z) through the single read port
// of the voxel RAM, each through a read state and a check state. Neighbours
// outside the chunk count as empty and skip the check state. Each empty
// neighbour then yields four vertex beats on out_valid/out_ready, one per
// cycle while out_ready is high, the final one flagged by last. in_ready is
// low while a command is in progress, so a new command is accepted only
// after a mesh command has finished. A stalled receiver holds the current
// vertex beat and the whole block. Reset clears the sequencer and the vertex
// counter; voxel contents are undefined until written.
module voxel_face_culling_mesher
  import vfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  state_t              state_r, state_nxt;
  logic [COORD_W-1:0]  x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [VOX_W-1:0]    me_r, me_nxt;
  logic [NFACES-1:0]   mask_r, mask_nxt;
  logic [FACE_W-1:0]   face_r, face_nxt;
  logic [CORN_W-1:0]   corner_r, corner_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                in_acc, out_acc, cell_inside;
  logic                wr_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [VOX_W-1:0]    rd_data;
  logic [COORD_W-1:0]  nb_x, nb_y, nb_z;
  logic                nb_out;
  logic [NFACES-1:0]   fin_mask;
  logic [FACE_W:0]     nf_emit, nf_fin;
  logic [2:0]          offs;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [COORD_W-1:0] ax,
                                                input logic [COORD_W-1:0] ay,
                                                input logic [COORD_W-1:0] az);
    return ADDR_W'((int'(az) * CHUNK_EDGE + int'(ay)) * CHUNK_EDGE + int'(ax));
  endfunction

  // first set face strictly above f, or from zero when from_start is set; MSB flags none
  function automatic logic [FACE_W:0] next_face(input logic [NFACES-1:0] m,
                                                input logic [FACE_W-1:0] f,
                                                input logic              from_start);
    logic [FACE_W:0] r;
    r = {1'b1, {FACE_W{1'b0}}};
    for (int i = NFACES - 1; i >= 0; i--) begin
      if (m[i] && (from_start || FACE_W'(i) > f)) begin
        r = {1'b0, FACE_W'(i)};
      end
    end
    return r;
  endfunction

  assign in_ready    = (state_r == S_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign out_valid   = (state_r == S_EMIT);
  assign out_acc     = out_valid && out_ready;
  assign cell_inside = (int'(in_data.cell_x) < CHUNK_EDGE) &&
                       (int'(in_data.cell_y) < CHUNK_EDGE) &&
                       (int'(in_data.cell_z) < CHUNK_EDGE);
  assign wr_en       = in_acc && (in_data.cmd == CMD_WRITE) && cell_inside;

  always_comb begin
    nb_x   = x_r;
    nb_y   = y_r;
    nb_z   = z_r;
    nb_out = 1'b0;
    case (face_r)
      3'd0: begin
        nb_x   = x_r + 1'b1;
        nb_out = int'({1'b0, x_r}) + 1 >= CHUNK_EDGE;
      end
      3'd1: begin
        nb_x   = x_r - 1'b1;
        nb_out = (x_r == '0);
      end
      3'd2: begin
        nb_y   = y_r + 1'b1;
        nb_out = int'({1'b0, y_r}) + 1 >= CHUNK_EDGE;
      end
      3'd3: begin
        nb_y   = y_r - 1'b1;
        nb_out = (y_r == '0);
      end
      3'd4: begin
        nb_z   = z_r + 1'b1;
        nb_out = int'({1'b0, z_r}) + 1 >= CHUNK_EDGE;
      end
      3'd5: begin
        nb_z   = z_r - 1'b1;
        nb_out = (z_r == '0);
      end
      default: nb_out = 1'b1;
    endcase
  end

  assign rd_addr = (state_r == S_NB_RD) ? addr_of(nb_x, nb_y, nb_z) : addr_of(x_r, y_r, z_r);

  vfc_ram #(
    .WIDTH (VOX_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr_of(in_data.cell_x, in_data.cell_y, in_data.cell_z)),
    .wr_data (in_data.voxel_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign nf_emit = next_face(mask_r, face_r, 1'b0);

  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    z_nxt      = z_r;
    me_nxt     = me_r;
    mask_nxt   = mask_r;
    face_nxt   = face_r;
    corner_nxt = corner_r;
    cnt_nxt    = cnt_r;
    fin_mask   = mask_r;
    nf_fin     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_nxt = in_data.cell_x;
          y_nxt = in_data.cell_y;
          z_nxt = in_data.cell_z;
          case (in_data.cmd)
            CMD_MESH: begin
              if (cell_inside) begin
                state_nxt = S_SELF_RD;
              end
            end
            CMD_CLEAR: cnt_nxt = '0;
            default: ;
          endcase
        end
      end
      S_SELF_RD: state_nxt = S_SELF_CHK;
      S_SELF_CHK: begin
        me_nxt   = rd_data;
        mask_nxt = '0;
        face_nxt = '0;
        state_nxt = (rd_data == '0) ? S_IDLE : S_NB_RD;
      end
      S_NB_RD, S_NB_CHK: begin
        if (state_r == S_NB_RD && !nb_out) begin
          state_nxt = S_NB_CHK;
        end else begin
          fin_mask[face_r] = (state_r == S_NB_RD) ? 1'b1 : (rd_data == '0);
          mask_nxt = fin_mask;
          nf_fin   = next_face(fin_mask, face_r, 1'b1);
          if (int'(face_r) == NFACES - 1) begin
            if (fin_mask == '0) begin
              state_nxt = S_IDLE;
            end else begin
              face_nxt   = nf_fin[FACE_W-1:0];
              corner_nxt = '0;
              state_nxt  = S_EMIT;
            end
          end else begin
            face_nxt  = face_r + 1'b1;
            state_nxt = S_NB_RD;
          end
        end
      end
      S_EMIT: begin
        if (out_acc) begin
          cnt_nxt    = cnt_r + 1'b1;
          corner_nxt = corner_r + 1'b1;
          if (corner_r == '1) begin
            if (nf_emit[FACE_W]) begin
              state_nxt = S_IDLE;
            end else begin
              face_nxt = nf_emit[FACE_W-1:0];
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    offs                   = FACE_CORNER[face_r][corner_r];
    out_data.vert_x        = VERT_W'(x_r) + VERT_W'(offs[2]);
    out_data.vert_y        = VERT_W'(y_r) + VERT_W'(offs[1]);
    out_data.vert_z        = VERT_W'(z_r) + VERT_W'(offs[0]);
    out_data.corner_code   = (CODE_W'(face_r) << 2) + (CODE_W'(face_r) << 1) +
                             CODE_W'(corner_r);
    out_data.vertex_type   = me_r;
    out_data.vertex_number = cnt_r;
    out_data.last          = (corner_r == '1) && nf_emit[FACE_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      mask_r   <= '0;
      face_r   <= '0;
      corner_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      mask_r   <= mask_nxt;
      face_r   <= face_nxt;
      corner_r <= corner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    z_r  <= z_nxt;
    me_r <= me_nxt;
  end

endmodule

/* rtl/core/vfc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module vfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for voxel_face_culling_mesher: command beats in,
// vertex beats out, each checked against an in-bench chunk and counter model.
// Depends on vfc_pkg and the mesher RTL.
`timescale 1ns / 1ps

module testbench;
  import vfc_pkg::*;

  localparam int          HALF_PERIOD    = 10;
  localparam int          RESET_CYCLES   = 7;
  localparam int          QUIET_LIMIT    = 4000;
  localparam int          HOLDOFF_CYCLES = 400;
  localparam int          DRAIN_CYCLES   = 60;
  localparam int          FILL_EDGE      = 3;
  localparam int          RANDOM_BEATS   = 16;
  localparam logic [1:0]  CMD_NOP        = 2'd3;

  localparam int FACE_STEP [6][3] = '{
    '{ 1, 0, 0}, '{-1, 0, 0}, '{ 0, 1, 0},
    '{ 0,-1, 0}, '{ 0, 0, 1}, '{ 0, 0,-1}
  };

  localparam int CORNER_OFS [6][4][3] = '{
    '{'{1,0,0}, '{1,1,0}, '{1,0,1}, '{1,1,1}},
    '{'{0,0,0}, '{0,1,0}, '{0,0,1}, '{0,1,1}},
    '{'{0,1,0}, '{0,1,1}, '{1,1,0}, '{1,1,1}},
    '{'{0,0,0}, '{1,0,0}, '{0,0,1}, '{1,0,1}},
    '{'{0,0,1}, '{0,1,1}, '{1,0,1}, '{1,1,1}},
    '{'{0,0,0}, '{0,1,0}, '{1,0,0}, '{1,1,0}}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  logic [VOX_W-1:0] chunk_mem [CELLS];
  logic [CNT_W-1:0] vertex_count = '0;
  out_beat_t        vertex_q [$];
  out_beat_t        next_vertex;
  int               errors = 0;
  int               quiet_cycles = 0;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               holdoff_reqs = 0;
  int               holdoff_taken = 0;
  int               holdoff_left = 0;

  voxel_face_culling_mesher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic logic [VOX_W-1:0] voxel_at(input int x, input int y, input int z);
    if (x < 0 || y < 0 || z < 0) return '0;
    if (x >= CHUNK_EDGE || y >= CHUNK_EDGE || z >= CHUNK_EDGE) return '0;
    return chunk_mem[(z * CHUNK_EDGE + y) * CHUNK_EDGE + x];
  endfunction

  task automatic predict_vertices(input in_beat_t b);
    int               x, y, z, last_face;
    logic             in_chunk;
    logic [VOX_W-1:0] self_val;
    logic [5:0]       exposed;
    out_beat_t        v;
    x = b.cell_x;
    y = b.cell_y;
    z = b.cell_z;
    in_chunk = (x < CHUNK_EDGE) && (y < CHUNK_EDGE) && (z < CHUNK_EDGE);
    case (b.cmd)
      CMD_WRITE: begin
        if (in_chunk) chunk_mem[(z * CHUNK_EDGE + y) * CHUNK_EDGE + x] = b.voxel_value;
      end
      CMD_CLEAR: vertex_count = '0;
      CMD_MESH: begin
        self_val = voxel_at(x, y, z);
        if (in_chunk && self_val != '0) begin
          last_face = -1;
          for (int f = 0; f < 6; f++) begin
            exposed[f] = voxel_at(x + FACE_STEP[f][0], y + FACE_STEP[f][1],
                                  z + FACE_STEP[f][2]) == '0;
            if (exposed[f]) last_face = f;
          end
          for (int f = 0; f < 6; f++) begin
            if (exposed[f]) begin
              for (int c = 0; c < 4; c++) begin
                v.vert_x        = VERT_W'(x + CORNER_OFS[f][c][0]);
                v.vert_y        = VERT_W'(y + CORNER_OFS[f][c][1]);
                v.vert_z        = VERT_W'(z + CORNER_OFS[f][c][2]);
                v.corner_code   = CODE_W'(f * 6 + c);
                v.vertex_type   = self_val;
                v.vertex_number = vertex_count;
                v.last          = (f == last_face) && (c == 3);
                vertex_q.push_back(v);
                vertex_count = vertex_count + 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_command(input in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    predict_vertices(b);
  endtask

  function automatic in_beat_t make_command(input logic [1:0] cmd, input int x, input int y,
                                            input int z, input int val);
    in_beat_t b;
    b.cmd         = cmd;
    b.cell_x      = COORD_W'(x);
    b.cell_y      = COORD_W'(y);
    b.cell_z      = COORD_W'(z);
    b.voxel_value = VOX_W'(val);
    return b;
  endfunction

  // keep meshes inside the filled corner so every read hits a written cell
  function automatic int random_coord(input int span);
    if (span > 1 && $urandom_range(7) == 0) return $urandom_range(15, 0);
    return $urandom_range(span, 0);
  endfunction

  function automatic in_beat_t random_command();
    int         pick;
    int         span;
    logic [1:0] cmd;
    pick = $urandom_range(99);
    if (pick < 45)      cmd = CMD_WRITE;
    else if (pick < 90) cmd = CMD_MESH;
    else if (pick < 95) cmd = CMD_CLEAR;
    else                cmd = CMD_NOP;
    span = (cmd == CMD_MESH) ? 1 : FILL_EDGE - 1;
    return make_command(cmd, random_coord(span), random_coord(span), random_coord(span),
                        ($urandom_range(2) == 0) ? 0 : $urandom_range(255));
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: vertex %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (vertex_q.size() == 0) begin
        $display("%0t ns: unexpected vertex beat, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        next_vertex = vertex_q.pop_front();
        check_field("vert_x", next_vertex.vert_x, out_data.vert_x);
        check_field("vert_y", next_vertex.vert_y, out_data.vert_y);
        check_field("vert_z", next_vertex.vert_z, out_data.vert_z);
        check_field("corner_code", next_vertex.corner_code, out_data.corner_code);
        check_field("vertex_type", next_vertex.vertex_type, out_data.vertex_type);
        check_field("vertex_number", next_vertex.vertex_number, out_data.vertex_number);
        check_field("last", next_vertex.last, out_data.last);
      end
    end
  end

  always @(posedge clk) begin
    if (holdoff_reqs != holdoff_taken) begin
      holdoff_taken <= holdoff_reqs;
      holdoff_left  <= HOLDOFF_CYCLES;
      out_ready     <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("voxel_face_culling_mesher verification failed");
        $finish;
      end
    end
  end

  task automatic test_fill_corner();
    for (int z = 0; z < FILL_EDGE; z++)
      for (int y = 0; y < FILL_EDGE; y++)
        for (int x = 0; x < FILL_EDGE; x++)
          send_command(make_command(CMD_WRITE, x, y, z,
                                    ((x + y + z) % 3 == 0) ? 0 : 9 * z + 3 * y + x + 1));
  endtask

  task automatic test_directed_faces();
    send_command(make_command(CMD_MESH, 1, 1, 1, 0));
    send_command(make_command(CMD_WRITE, 0, 0, 0, 255));
    send_command(make_command(CMD_MESH, 0, 0, 0, 0));
    send_command(make_command(CMD_WRITE, 15, 15, 15, 1));
    send_command(make_command(CMD_WRITE, 14, 15, 15, 0));
    send_command(make_command(CMD_WRITE, 15, 14, 15, 6));
    send_command(make_command(CMD_WRITE, 15, 15, 14, 0));
    send_command(make_command(CMD_MESH, 15, 15, 15, 255));
    send_command(make_command(CMD_NOP, 0, 0, 0, 255));
    send_command(make_command(CMD_CLEAR, 15, 15, 15, 0));
    send_command(make_command(CMD_WRITE, 1, 1, 1, 8'h80));
    for (int f = 0; f < 6; f++)
      send_command(make_command(CMD_WRITE, 1 + FACE_STEP[f][0], 1 + FACE_STEP[f][1],
                                1 + FACE_STEP[f][2], f + 1));
    send_command(make_command(CMD_MESH, 1, 1, 1, 0));
    send_command(make_command(CMD_MESH, 0, 1, 1, 0));
    send_command(make_command(CMD_WRITE, 1, 1, 1, 0));
    send_command(make_command(CMD_MESH, 1, 1, 1, 0));
    send_command(make_command(CMD_WRITE, 0, 0, 0, 0));
    send_command(make_command(CMD_MESH, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall, input int count);
    send_idle_pct = idle_pct;
    stall_pct    <= stall;
    repeat (count) send_command(random_command());
  endtask

  task automatic test_output_holdoff();
    send_idle_pct = 0;
    stall_pct    <= 0;
    send_command(make_command(CMD_WRITE, 0, 0, 0, 8'h3C));
    holdoff_reqs <= holdoff_reqs + 1;
    repeat (6) send_command(make_command(CMD_MESH, 0, 0, 0, 0));
    repeat (6) send_command(random_command());
  endtask

  initial begin
    foreach (chunk_mem[i]) chunk_mem[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_corner();
    test_directed_faces();
    test_random_traffic(0, 0, RANDOM_BEATS);
    test_random_traffic(84, 0, RANDOM_BEATS);
    test_random_traffic(0, 84, RANDOM_BEATS);
    test_random_traffic(10, 10, RANDOM_BEATS);
    test_output_holdoff();

    in_valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("voxel_face_culling_mesher verification clean");
    end else begin
      $display("voxel_face_culling_mesher verification failed");
    end
    $finish;
  end

endmodule
